// File: hdl/fsip_pkg.sv
// ----------------------------------------------------------------------------
// fsip_pkg
// Shared types, character codes and helpers of the printf-style integer
// printer: parser phases, action codes and the sequencer state.
// ----------------------------------------------------------------------------
package fsip_pkg;

  localparam int ARG_WIDTH_DEF = 32;
  localparam int MAX_RESULTS   = 11;
  localparam int OCNT_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] FORMAT_LIMIT_RESET = 8'd128;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UP_N    = 8'h4E;
  localparam logic [7:0] CHAR_UP_S    = 8'h53;
  localparam logic [7:0] CHAR_LO_A    = 8'h61;
  localparam logic [7:0] CHAR_LO_C    = 8'h63;
  localparam logic [7:0] CHAR_LO_D    = 8'h64;
  localparam logic [7:0] CHAR_LO_H    = 8'h68;
  localparam logic [7:0] CHAR_LO_I    = 8'h69;
  localparam logic [7:0] CHAR_LO_L    = 8'h6C;
  localparam logic [7:0] CHAR_LO_S    = 8'h73;
  localparam logic [7:0] CHAR_LO_U    = 8'h75;

  typedef enum logic [2:0] {
    PH_LITERAL = 3'd0,
    PH_FLAG    = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_H       = 3'd3,
    PH_L       = 3'd4,
    PH_SPEC    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    LEN_INT = 2'd0,
    LEN_L   = 2'd1,
    LEN_LL  = 2'd2
  } len_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_TEXT3 = 2'd2,
    ACT_DEC   = 2'd3
  } act_kind_t;

  // what one format character asks the output sequencer to do
  typedef struct packed {
    act_kind_t  kind;
    logic [7:0] ch;
    logic       neg;
  } action_t;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_CONV = 2'd1,
    SQ_EMIT = 2'd2
  } seq_state_t;

  // decimal digits needed for a w-bit unsigned value (w*log10(2), rounded up)
  function automatic int dec_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

endpackage

// File: hdl/format_string_integer_printer_core.sv
// ----------------------------------------------------------------------------
// format_string_integer_printer_core
// Character-serial printf-style formatter for integer arguments.
// ----------------------------------------------------------------------------
// Format characters are taken one beat at a time and the block stays stalled
// until the run of output characters for that beat has been loaded into the
// output register. A literal or %c character emits one character, %s and
// %lld style conversions three, and a decimal conversion first runs in the
// shared shift-and-add-3 converter and then emits one character per load,
// up to 11 (sign and ten digits for a 32-bit argument). Flag, width and
// length characters emit nothing and do not stall the input. Backpressure
// on the output channel holds the run and so the input. The last character
// of each run carries out_last. The format limit register is written through
// the cfg port and must only change while the block is idle.
module format_string_integer_printer_core import fsip_pkg::*; #(
  parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_format_char,
  input  logic [31:0] in_argument,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int ND = dec_digits(ARG_WIDTH);
  localparam int DW = $clog2(ND);
  localparam logic [1:0]        TEXT_LAST = 2'd2;
  localparam logic [OCNT_W-1:0] OCNT_LAST = OCNT_W'(MAX_RESULTS - 1);

  seq_state_t           state_r, state_nxt;
  logic [7:0]           limit_r;
  act_kind_t            kind_r, kind_nxt;
  logic [7:0]           ch_r, ch_nxt;
  logic                 neg_r, neg_nxt;
  logic [1:0]           tidx_r, tidx_nxt;
  logic [DW-1:0]        didx_r, didx_nxt;
  logic [OCNT_W-1:0]    ocnt_r, ocnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_accept, out_free, load;
  logic [7:0]           emit_ch;
  logic                 emit_last;
  action_t              act;
  logic [ARG_WIDTH-1:0] act_value;
  logic                 dab_start, dab_busy;
  logic [DW-1:0]        dab_top;
  logic [3:0]           dab_digit;

  assign in_stall  = (state_r != SQ_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  fsip_parser #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .format_char (in_format_char),
    .argument    (in_argument),
    .first       (in_first),
    .limit       (limit_r),
    .act         (act),
    .act_value   (act_value)
  );

  assign dab_start = in_accept && (act.kind == ACT_DEC);

  fsip_dabble #(
    .ARG_WIDTH (ARG_WIDTH)
  ) u_dabble (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dab_start),
    .value   (act_value),
    .sel_idx (didx_r),
    .busy    (dab_busy),
    .top_idx (dab_top),
    .digit   (dab_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= FORMAT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= ACT_NONE;
      neg_r       <= 1'b0;
      tidx_r      <= '0;
      didx_r      <= '0;
      ocnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      neg_r       <= neg_nxt;
      tidx_r      <= tidx_nxt;
      didx_r      <= didx_nxt;
      ocnt_r      <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // character picked for the next output beat
  always_comb begin
    emit_ch   = ch_r;
    emit_last = 1'b1;
    case (kind_r)
      ACT_TEXT3: begin
        emit_last = (tidx_r == TEXT_LAST);
        if (tidx_r == 2'd0) begin
          emit_ch = CHAR_UP_N;
        end else if (tidx_r == 2'd1) begin
          emit_ch = CHAR_LO_A;
        end else begin
          emit_ch = ch_r;
        end
      end
      ACT_DEC: begin
        if (neg_r) begin
          emit_ch   = CHAR_MINUS;
          emit_last = 1'b0;
        end else begin
          emit_ch   = CHAR_ZERO | {4'd0, dab_digit};
          emit_last = (didx_r == '0) || (ocnt_r == OCNT_LAST);
        end
      end
      default: begin
        emit_ch   = ch_r;
        emit_last = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == SQ_EMIT) && out_free;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    ch_nxt        = ch_r;
    neg_nxt       = neg_r;
    tidx_nxt      = tidx_r;
    didx_nxt      = didx_r;
    ocnt_nxt      = ocnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      SQ_IDLE: begin
        if (in_accept && act.kind != ACT_NONE) begin
          kind_nxt = act.kind;
          ch_nxt   = act.ch;
          neg_nxt  = act.neg;
          tidx_nxt = '0;
          ocnt_nxt = '0;
          state_nxt = (act.kind == ACT_DEC) ? SQ_CONV : SQ_EMIT;
        end
      end
      SQ_CONV: begin
        if (!dab_busy) begin
          didx_nxt  = dab_top;
          state_nxt = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = emit_ch;
          out_last_nxt  = emit_last;
          tidx_nxt      = tidx_r + 2'd1;
          if (kind_r == ACT_DEC) begin
            ocnt_nxt = ocnt_r + 1'b1;
            if (neg_r) begin
              neg_nxt = 1'b0;
            end else begin
              didx_nxt = didx_r - 1'b1;
            end
          end
          if (emit_last) begin
            state_nxt = SQ_IDLE;
          end
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  // the converter only runs while the sequencer waits for it
  a_dab_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    dab_busy |-> (state_r == SQ_CONV))
    else $error("digit converter busy outside conversion");

  // a run never exceeds the result limit
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OCNT_W'(MAX_RESULTS))
    else $error("too many characters in one run");

  // the closing beat of a run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && emit_last) |=> (state_r == SQ_IDLE))
    else $error("sequencer not idle after closing beat");

  // digits coming out of the converter are decimal
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load && kind_r == ACT_DEC && !neg_r) |-> (dab_digit <= 4'd9))
    else $error("non-decimal digit emitted");

  // an output beat is loaded only when the register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load)
    else $error("stalled output beat overwritten");

endmodule

// File: hdl/fsip_parser.sv
// ----------------------------------------------------------------------------
// fsip_parser
// Format string parser: tracks the conversion phase, length modifier,
// character position and end of string, and decodes each accepted
// character into one output action.
// ----------------------------------------------------------------------------
module fsip_parser import fsip_pkg::*; #(
  parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           format_char,
  input  logic [31:0]          argument,
  input  logic                 first,
  input  logic [7:0]           limit,
  output action_t              act,
  output logic [ARG_WIDTH-1:0] act_value
);

  phase_t         phase_r, phase_nxt, ph_e;
  len_t           len_r, len_nxt, len_e, spec_len;
  logic [7:0]     cnt_r, cnt_nxt, cnt_e;
  logic           ended_r, ended_nxt, end_e;
  logic           do_spec, do_lit, is_digit, is_flag;
  logic [ARG_WIDTH-1:0] v;
  logic           v_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LITERAL;
      len_r   <= LEN_INT;
      cnt_r   <= '0;
      ended_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
    end
  end

  assign v     = ARG_WIDTH'(argument);
  assign v_neg = v[ARG_WIDTH-1];

  always_comb begin
    ph_e  = first ? PH_LITERAL : phase_r;
    len_e = first ? LEN_INT : len_r;
    cnt_e = first ? 8'd0 : cnt_r;
    end_e = first ? 1'b0 : ended_r;

    phase_nxt = ph_e;
    len_nxt   = len_e;
    cnt_nxt   = cnt_e;
    ended_nxt = end_e;
    do_spec   = 1'b0;
    do_lit    = 1'b0;
    spec_len  = len_e;
    act       = '{kind: ACT_NONE, ch: format_char, neg: 1'b0};
    act_value = v;

    is_digit = format_char inside {[CHAR_ZERO:CHAR_NINE]};
    is_flag  = format_char inside {CHAR_PLUS, CHAR_MINUS, CHAR_SPACE, CHAR_HASH, CHAR_ZERO};

    if (!end_e) begin
      if (cnt_e != 8'hFF) begin
        cnt_nxt = cnt_e + 8'd1;
      end

      case (ph_e)
        PH_FLAG, PH_WIDTH: begin
          if ((ph_e == PH_FLAG && is_flag) || is_digit) begin
            phase_nxt = PH_WIDTH;
          end else if (format_char == CHAR_LO_H) begin
            phase_nxt = PH_H;
          end else if (format_char == CHAR_LO_L) begin
            phase_nxt = PH_L;
          end else begin
            do_spec  = 1'b1;
            spec_len = LEN_INT;
          end
        end
        PH_H: begin
          len_nxt = LEN_INT;
          if (format_char == CHAR_LO_H) begin
            phase_nxt = PH_SPEC;
          end else begin
            do_spec  = 1'b1;
            spec_len = LEN_INT;
          end
        end
        PH_L: begin
          if (format_char == CHAR_LO_L) begin
            len_nxt   = LEN_LL;
            phase_nxt = PH_SPEC;
          end else begin
            len_nxt  = LEN_L;
            do_spec  = 1'b1;
            spec_len = LEN_L;
          end
        end
        PH_SPEC: begin
          do_spec = 1'b1;
        end
        default: begin
          phase_nxt = PH_LITERAL;
          do_lit    = 1'b1;
        end
      endcase

      if (do_spec) begin
        phase_nxt = PH_LITERAL;
        len_nxt   = LEN_INT;
        case (format_char)
          CHAR_LO_D, CHAR_LO_I: begin
            if (spec_len == LEN_LL) begin
              act.kind = ACT_TEXT3;
              act.ch   = CHAR_UP_N;
            end else begin
              act.kind = ACT_DEC;
              act.neg  = v_neg;
              if (v_neg) begin
                act_value = ~v + 1'b1;
              end
            end
          end
          CHAR_LO_U: begin
            if (spec_len == LEN_LL) begin
              act.kind = ACT_TEXT3;
              act.ch   = CHAR_UP_N;
            end else begin
              act.kind = ACT_DEC;
            end
          end
          CHAR_LO_C: begin
            act.kind = ACT_CHAR;
            act.ch   = argument[7:0];
          end
          CHAR_LO_S: begin
            act.kind = ACT_TEXT3;
            act.ch   = CHAR_UP_S;
          end
          default: begin
            // unknown specifier falls back to literal handling
            do_lit = 1'b1;
          end
        endcase
      end

      if (do_lit) begin
        if (cnt_e >= limit || format_char == CHAR_NUL) begin
          ended_nxt = 1'b1;
          phase_nxt = PH_LITERAL;
        end else if (format_char == CHAR_PERCENT) begin
          phase_nxt = PH_FLAG;
          len_nxt   = LEN_INT;
        end else begin
          act.kind = ACT_CHAR;
          act.ch   = format_char;
        end
      end
    end
  end

endmodule

// File: hdl/fsip_dabble.sv
// ----------------------------------------------------------------------------
// fsip_dabble
// Shared binary to decimal unit: shift-and-add-3 conversion, four bits
// per cycle, with a digit read port and a leading digit index.
// ----------------------------------------------------------------------------
module fsip_dabble import fsip_pkg::*; #(
  parameter int ARG_WIDTH = ARG_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [ARG_WIDTH-1:0]                    value,
  input  logic [$clog2(dec_digits(ARG_WIDTH))-1:0] sel_idx,
  output logic                                    busy,
  output logic [$clog2(dec_digits(ARG_WIDTH))-1:0] top_idx,
  output logic [3:0]                              digit
);

  localparam int BITS_PER_STEP = 4;
  localparam int PW     = ((ARG_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
  localparam int STEPS  = PW / BITS_PER_STEP;
  localparam int ND     = dec_digits(ARG_WIDTH);
  localparam int DW     = $clog2(ND);
  localparam int CW     = $clog2(STEPS + 1);

  logic [PW-1:0]   bin_r, bin_nxt;
  logic [ND*4-1:0] bcd_r, bcd_nxt;
  logic [CW-1:0]   cnt_r;

  assign busy = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= PW'(value);
      bcd_r <= '0;
    end else if (busy) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  // four add-3 / shift steps per cycle
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_nxt[d*4 +: 4] >= 4'd5) begin
          bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt[ND*4-2:0], bin_nxt, 1'b0};
    end
  end

  always_comb begin
    top_idx = '0;
    for (int d = 0; d < ND; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        top_idx = DW'(d);
      end
    end
  end

  assign digit = bcd_r[sel_idx*4 +: 4];

endmodule
